@@ rtl/core/apnh_pkg.sv @@
// ----------------------------------------------------------------------------
// apnh_pkg
// Shared constants and types for the all-pairs next-hop table block.
// ----------------------------------------------------------------------------
package apnh_pkg;

    // Node limits and configuration register
    localparam int MAX_NODES_DEF = 16;
    localparam int NODE_CNT_W    = 5;
    localparam logic [NODE_CNT_W-1:0] NODE_CNT_RESET = 5'd16;

    // Distance and hop encodings
    localparam int DIST_W = 6;
    localparam logic [DIST_W-1:0] DIST_INF  = 6'd63;
    localparam logic [DIST_W-1:0] DIST_LINK = 6'd1;
    localparam logic [DIST_W-1:0] DIST_SELF = 6'd0;
    localparam int HOP_W  = 4;

    // Port-side field widths
    localparam int ADJ_W      = 16;
    localparam int SRC_W      = 4;
    localparam int HOPS_W     = 64;
    localparam int MASK_W     = 16;
    localparam int OUT_DATA_W = 88;
    localparam int PORT_LANES = 16;

    // Row queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // APB map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KRD,
        ST_KLAT,
        ST_RELAX,
        ST_ERD,
        ST_ELD
    } t_back_state;

endpackage

@@ rtl/core/apnh_ram.sv @@
// ----------------------------------------------------------------------------
// apnh_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module apnh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/apnh_fifo.sv @@
// ----------------------------------------------------------------------------
// apnh_fifo
// Small register FIFO that decouples row intake from the table engine.
// ----------------------------------------------------------------------------
module apnh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = apnh_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [AW:0]      r_count;
    logic [AW-1:0]    n_wptr;
    logic [AW-1:0]    n_rptr;
    logic [AW:0]      n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

@@ rtl/core/apnh_front.sv @@
// ----------------------------------------------------------------------------
// apnh_front
// Row intake: numbers each adjacency row, builds its initial distance row
// and marks the row that completes the table.
// ----------------------------------------------------------------------------
module apnh_front #(
    parameter int MAX_NODES = apnh_pkg::MAX_NODES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_clear,
    input  logic [$clog2(MAX_NODES+1)-1:0]         i_node_cnt,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [apnh_pkg::ADJ_W-1:0]             i_adj,
    input  logic                                   i_q_full,
    output logic                                   o_q_push,
    output logic                                   o_q_last,
    output logic [$clog2(MAX_NODES)-1:0]           o_q_row,
    output logic [MAX_NODES*apnh_pkg::DIST_W-1:0]  o_q_dist
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int DWD = apnh_pkg::DIST_W;

    logic [CW-1:0] r_rows_loaded;
    logic [CW-1:0] n_rows_loaded;
    logic [CW-1:0] row;
    logic [CW-1:0] row_next;
    logic          accept;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign o_q_push = accept;

    // Restart at row zero if the count is out of range
    assign row      = (r_rows_loaded >= i_node_cnt) ? '0 : r_rows_loaded;
    assign row_next = row + 1'b1;
    assign o_q_last = (row_next == i_node_cnt);
    assign o_q_row  = row[IW-1:0];

    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            if ((CW'(j) < i_node_cnt) && i_adj[j]) begin
                o_q_dist[j*DWD +: DWD] = apnh_pkg::DIST_LINK;
            end else if (CW'(j) == row) begin
                o_q_dist[j*DWD +: DWD] = apnh_pkg::DIST_SELF;
            end else begin
                o_q_dist[j*DWD +: DWD] = apnh_pkg::DIST_INF;
            end
        end
    end

    always_comb begin
        n_rows_loaded = r_rows_loaded;
        if (i_clear) begin
            n_rows_loaded = '0;
        end else if (accept) begin
            n_rows_loaded = o_q_last ? '0 : row_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_loaded <= '0;
        end else begin
            r_rows_loaded <= n_rows_loaded;
        end
    end

endmodule

@@ rtl/core/apnh_back.sv @@
// ----------------------------------------------------------------------------
// apnh_back
// Table engine: stores rows, runs lane-parallel shortest-path relaxation
// over pivots, then emits one next-hop row per source node.
// ----------------------------------------------------------------------------
module apnh_back #(
    parameter int MAX_NODES = apnh_pkg::MAX_NODES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [$clog2(MAX_NODES+1)-1:0]         i_node_cnt,
    input  logic                                   i_q_valid,
    output logic                                   o_q_pop,
    input  logic                                   i_q_last,
    input  logic [$clog2(MAX_NODES)-1:0]           i_q_row,
    input  logic [MAX_NODES*apnh_pkg::DIST_W-1:0]  i_q_dist,
    output logic                                   o_m_valid,
    input  logic                                   i_m_ready,
    output logic [apnh_pkg::SRC_W-1:0]             o_m_source,
    output logic [apnh_pkg::HOPS_W-1:0]            o_m_hops,
    output logic [apnh_pkg::MASK_W-1:0]            o_m_mask,
    output logic                                   o_m_last
);

    localparam int IW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int DWD = apnh_pkg::DIST_W;
    localparam int HWD = apnh_pkg::HOP_W;
    localparam int DW  = MAX_NODES * DWD;
    localparam int HW  = MAX_NODES * HWD;

    apnh_pkg::t_back_state r_state;
    apnh_pkg::t_back_state n_state;

    logic [IW-1:0] r_k;
    logic [IW-1:0] n_k;
    logic [CW-1:0] r_i;
    logic [CW-1:0] n_i;
    logic [IW-1:0] r_pi;
    logic [IW-1:0] n_pi;
    logic [DW-1:0] r_krow;
    logic [DW-1:0] n_krow;

    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [apnh_pkg::SRC_W-1:0]  r_out_source;
    logic [apnh_pkg::SRC_W-1:0]  n_out_source;
    logic [apnh_pkg::HOPS_W-1:0] r_out_hops;
    logic [apnh_pkg::HOPS_W-1:0] n_out_hops;
    logic [apnh_pkg::MASK_W-1:0] r_out_mask;
    logic [apnh_pkg::MASK_W-1:0] n_out_mask;
    logic                        r_out_last;
    logic                        n_out_last;

    logic          ram_wr_en;
    logic [IW-1:0] ram_wr_addr;
    logic [DW-1:0] dist_wr;
    logic [HW-1:0] hop_wr;
    logic          ram_rd_en;
    logic [IW-1:0] ram_rd_addr;
    logic [DW-1:0] dist_rd;
    logic [HW-1:0] hop_rd;

    logic [HW-1:0]               init_hops;
    logic [DW-1:0]               relax_dist;
    logic [HW-1:0]               relax_hop;
    logic [DWD-1:0]              aik;
    logic [HWD-1:0]              hik;
    logic [apnh_pkg::HOPS_W-1:0] emit_hops;
    logic [apnh_pkg::MASK_W-1:0] emit_mask;
    logic [CW-1:0]               last_idx;

    apnh_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_dist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (dist_wr),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (dist_rd)
    );

    apnh_ram #(.WIDTH(HW), .DEPTH(MAX_NODES)) u_hop_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (hop_wr),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (hop_rd)
    );

    assign last_idx = i_node_cnt - 1'b1;

    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            init_hops[j*HWD +: HWD] = HWD'(j);
        end
    end

    // Row i against pivot row k: all lanes in parallel. Row k and column k
    // do not change during pivot k, so one pass per row is exact.
    assign aik = dist_rd[r_k*DWD +: DWD];
    assign hik = hop_rd[r_k*HWD +: HWD];

    always_comb begin
        logic [DWD-1:0] b;
        logic [DWD-1:0] dij;
        logic [DWD:0]   sum;
        for (int j = 0; j < MAX_NODES; j++) begin
            b   = r_krow[j*DWD +: DWD];
            dij = dist_rd[j*DWD +: DWD];
            sum = {1'b0, aik} + {1'b0, b};
            if ((aik != apnh_pkg::DIST_INF) && (b != apnh_pkg::DIST_INF) &&
                (sum < {1'b0, dij})) begin
                relax_dist[j*DWD +: DWD] = sum[DWD-1:0];
                relax_hop[j*HWD +: HWD]  = hik;
            end else begin
                relax_dist[j*DWD +: DWD] = dij;
                relax_hop[j*HWD +: HWD]  = hop_rd[j*HWD +: HWD];
            end
        end
    end

    // Zero the lanes past the node count
    always_comb begin
        emit_hops = '0;
        emit_mask = '0;
        for (int j = 0; j < MAX_NODES; j++) begin
            if (CW'(j) < i_node_cnt) begin
                emit_hops[j*HWD +: HWD] = hop_rd[j*HWD +: HWD];
                emit_mask[j] = (dist_rd[j*DWD +: DWD] != apnh_pkg::DIST_INF);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_i          = r_i;
        n_pi         = r_pi;
        n_krow       = r_krow;
        n_out_valid  = r_out_valid && !i_m_ready;
        n_out_source = r_out_source;
        n_out_hops   = r_out_hops;
        n_out_mask   = r_out_mask;
        n_out_last   = r_out_last;
        o_q_pop      = 1'b0;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_pi;
        dist_wr      = relax_dist;
        hop_wr       = relax_hop;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_k;
        unique case (r_state)
            apnh_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop     = 1'b1;
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = i_q_row;
                    dist_wr     = i_q_dist;
                    hop_wr      = init_hops;
                    if (i_q_last) begin
                        n_k     = '0;
                        n_state = apnh_pkg::ST_KRD;
                    end
                end
            end
            apnh_pkg::ST_KRD: begin
                ram_rd_en = 1'b1;
                n_state   = apnh_pkg::ST_KLAT;
            end
            apnh_pkg::ST_KLAT: begin
                // Latch the pivot row, fetch row zero
                n_krow      = dist_rd;
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                n_pi        = '0;
                n_i         = CW'(1);
                n_state     = apnh_pkg::ST_RELAX;
            end
            apnh_pkg::ST_RELAX: begin
                // Write back the row fetched last cycle, fetch the next one if any remain
                ram_wr_en = 1'b1;
                if (r_i < i_node_cnt) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = r_i[IW-1:0];
                    n_pi        = r_i[IW-1:0];
                    n_i         = r_i + 1'b1;
                end else if (CW'(r_k) == last_idx) begin
                    n_i     = '0;
                    n_state = apnh_pkg::ST_ERD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = apnh_pkg::ST_KRD;
                end
            end
            apnh_pkg::ST_ERD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_i[IW-1:0];
                n_state     = apnh_pkg::ST_ELD;
            end
            apnh_pkg::ST_ELD: begin
                // Hold the read data until the output register frees up
                if (!r_out_valid || i_m_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_source = apnh_pkg::SRC_W'(r_i);
                    n_out_hops   = emit_hops;
                    n_out_mask   = emit_mask;
                    n_out_last   = (r_i == last_idx);
                    if (r_i == last_idx) begin
                        n_state = apnh_pkg::ST_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = apnh_pkg::ST_ERD;
                    end
                end
            end
            default: begin
                n_state = apnh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apnh_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_i          <= n_i;
        r_pi         <= n_pi;
        r_krow       <= n_krow;
        r_out_source <= n_out_source;
        r_out_hops   <= n_out_hops;
        r_out_mask   <= n_out_mask;
        r_out_last   <= n_out_last;
    end

    assign o_m_valid  = r_out_valid;
    assign o_m_source = r_out_source;
    assign o_m_hops   = r_out_hops;
    assign o_m_mask   = r_out_mask;
    assign o_m_last   = r_out_last;

endmodule

@@ rtl/core/all_pairs_next_hop_table.sv @@
// ----------------------------------------------------------------------------
// all_pairs_next_hop_table
// Next-hop routing table from adjacency rows by all-pairs relaxation.
// ----------------------------------------------------------------------------
// Flow: rows are accepted whenever the two-row queue is not full. After the
//   last row, the engine runs one pivot pass per node (read the pivot row,
//   latch it, relax every row), then reads and emits one result row per
//   source node, holding each while m_axis_tready is low. The queue decouples
//   intake from the engine; intake stalls while the queue is full.
// Reset: synchronous, active low; node_count returns to 16, row count to 0.
module all_pairs_next_hop_table #(
    parameter int MAX_NODES = apnh_pkg::MAX_NODES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [apnh_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [apnh_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [apnh_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Adjacency rows
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [apnh_pkg::ADJ_W-1:0]          s_axis_tdata,  // [15:0] adjacency_row
    // Next-hop rows
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [3:0] source_node, [67:4] next_hops, [83:68] reachable_mask, [87:84] zero
    output logic [apnh_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast   // last_row
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int DW = MAX_NODES * apnh_pkg::DIST_W;
    localparam int QW = 1 + IW + DW;

    logic [apnh_pkg::NODE_CNT_W-1:0] r_node_count;
    logic [apnh_pkg::NODE_CNT_W-1:0] n_node_count;
    logic                            cfg_wr;
    logic                            cfg_hit;
    logic [CW-1:0]                   node_cnt;

    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic          f_last;
    logic [IW-1:0] f_row;
    logic [DW-1:0] f_dist;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_out;

    logic [apnh_pkg::SRC_W-1:0]  m_source;
    logic [apnh_pkg::HOPS_W-1:0] m_hops;
    logic [apnh_pkg::MASK_W-1:0] m_mask;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[apnh_pkg::APB_ADDR_W-1:2] == apnh_pkg::REG_NODE_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? apnh_pkg::APB_DATA_W'(r_node_count) : '0;

    always_comb begin
        n_node_count = r_node_count;
        if (cfg_wr) begin
            n_node_count = pwdata[apnh_pkg::NODE_CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= apnh_pkg::NODE_CNT_RESET;
        end else begin
            r_node_count <= n_node_count;
        end
    end

    // Clamp the node count into 1..MAX_NODES
    always_comb begin
        if (r_node_count == '0) begin
            node_cnt = CW'(1);
        end else if (r_node_count > apnh_pkg::NODE_CNT_W'(MAX_NODES)) begin
            node_cnt = CW'(MAX_NODES);
        end else begin
            node_cnt = CW'(r_node_count);
        end
    end

    apnh_front #(.MAX_NODES(MAX_NODES)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (cfg_wr),
        .i_node_cnt (node_cnt),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_adj      (s_axis_tdata),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_last   (f_last),
        .o_q_row    (f_row),
        .o_q_dist   (f_dist)
    );

    assign q_in = {f_last, f_row, f_dist};

    apnh_fifo #(.WIDTH(QW), .DEPTH(apnh_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    apnh_back #(.MAX_NODES(MAX_NODES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_node_cnt (node_cnt),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_q_last   (q_out[QW-1]),
        .i_q_row    (q_out[DW +: IW]),
        .i_q_dist   (q_out[DW-1:0]),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_source (m_source),
        .o_m_hops   (m_hops),
        .o_m_mask   (m_mask),
        .o_m_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, m_mask, m_hops, m_source};

endmodule
